// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit hole allocator: widths, codes, controller states
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int AddrW = 47;
  localparam int HoleSlots = 16;
  localparam int SlotW = (HoleSlots > 1) ? $clog2(HoleSlots) : 1;
  localparam logic [AddrW-1:0] ArenaBaseReset = 47'h0_0001_0000_0000;
  localparam logic [AddrW-1:0] ArenaLimitReset = 47'h0_0010_0000_0000;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StExhausted = 2'd1;
  localparam logic [1:0] StLeaked = 2'd2;
  localparam logic [1:0] StOutside = 2'd3;

  localparam logic RegArenaBase = 1'b0;
  localparam logic RegArenaLimit = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ASCAN, S_BUMP, S_FCHECK, S_FSCAN, S_FPLACE, S_OUT
  } state_t;

  typedef struct packed {
    logic clr_ptr;
    logic inc_ptr;
    logic clear_wr;
    logic load;
    logic trim;
    logic bump;
    logic merge;
    logic place;
    logic set_exh;
    logic set_out;
    logic set_leak;
  } ctl_t;

  typedef struct packed {
    logic ptr_last;
    logic is_free;
    logic fit;
    logic bump_ok;
    logic outside;
    logic overlap;
    logic empty;
  } sts_t;
endpackage

// ===== rtl/ffha_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller state machine for the hole allocator.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_ctrl import ffha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);
  state_t state, state_next;
  logic wait_rd, wait_rd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      wait_rd <= 1'b0;
    end else begin
      state <= state_next;
      wait_rd <= wait_rd_next;
    end
  end

  always_comb begin
    state_next = state;
    wait_rd_next = 1'b0;
    case (state)
      S_CLEAR: if (sts.ptr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) begin
        state_next = sts.is_free ? S_FCHECK : S_ASCAN;
        wait_rd_next = 1'b1;
      end
      S_ASCAN: if (wait_rd) begin
        wait_rd_next = 1'b0;
      end else if (sts.fit) begin
        state_next = S_OUT;
      end else if (sts.ptr_last) begin
        state_next = S_BUMP;
      end else begin
        wait_rd_next = 1'b1;
      end
      S_BUMP: state_next = S_OUT;
      S_FCHECK: begin
        state_next = sts.outside ? S_OUT : S_FSCAN;
      end
      S_FSCAN: if (wait_rd) begin
        wait_rd_next = 1'b0;
      end else if (sts.overlap || !sts.ptr_last) begin
        wait_rd_next = 1'b1;
      end else begin
        state_next = S_FPLACE;
        wait_rd_next = 1'b1;
      end
      S_FPLACE: if (wait_rd) begin
        wait_rd_next = 1'b0;
      end else if (sts.empty || sts.ptr_last) begin
        state_next = S_OUT;
      end else begin
        wait_rd_next = 1'b1;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    busy = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        ctl.inc_ptr = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.clr_ptr = 1'b1;
        ctl.load = in_valid;
      end
      S_ASCAN: if (!wait_rd) begin
        if (sts.fit) ctl.trim = 1'b1;
        else ctl.inc_ptr = 1'b1;
      end
      S_BUMP: begin
        if (sts.bump_ok) ctl.bump = 1'b1;
        else ctl.set_exh = 1'b1;
      end
      S_FCHECK: begin
        ctl.set_out = sts.outside;
        ctl.clr_ptr = 1'b1;
      end
      S_FSCAN: if (!wait_rd) begin
        if (sts.overlap) begin
          ctl.merge = 1'b1;
          ctl.clr_ptr = 1'b1;
        end else if (sts.ptr_last) begin
          ctl.clr_ptr = 1'b1;
        end else begin
          ctl.inc_ptr = 1'b1;
        end
      end
      S_FPLACE: if (!wait_rd) begin
        if (sts.empty) ctl.place = 1'b1;
        else if (sts.ptr_last) ctl.set_leak = 1'b1;
        else ctl.inc_ptr = 1'b1;
      end
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== rtl/ffha_dp.sv =====
// Datapath: hole table RAMs, slot pointer, bump pointer, arena registers and
// the working range. Depends on ffha_pkg and ffha_ram.
`timescale 1ns / 1ps
module ffha_dp import ffha_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  output sts_t             sts,
  input  logic             busy,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [AddrW-1:0] cfg_data,
  input  logic             cmd_in,
  input  logic [AddrW-1:0] base_in,
  input  logic [AddrW-1:0] size_in,
  output logic [AddrW-1:0] granted,
  output logic [1:0]       stat
);
  logic [AddrW-1:0] arena_base, arena_limit, bump_pointer;
  logic [AddrW-1:0] lo, hi, size;
  logic             is_free;
  logic [SlotW:0]   ptr;
  logic [AddrW-1:0] hs, hl;
  logic             we;
  logic [AddrW-1:0] ws, wl;
  logic [AddrW:0]   he, bsum;

  assign he = {1'b0, hs} + {1'b0, hl};
  assign bsum = {1'b0, bump_pointer} + {1'b0, size};

  always_comb begin
    we = 1'b0;
    ws = '0;
    wl = '0;
    if (ctl.clear_wr || ctl.merge) begin
      we = 1'b1;
    end else if (ctl.trim) begin
      we = 1'b1;
      ws = hs + size;
      wl = hl - size;
    end else if (ctl.place) begin
      we = 1'b1;
      ws = lo;
      wl = hi - lo;
    end
  end

  ffha_ram #(.Width(AddrW), .Depth(HoleSlots)) u_start (
    .clk, .we, .addr(ptr[SlotW-1:0]), .wdata(ws), .rdata(hs));
  ffha_ram #(.Width(AddrW), .Depth(HoleSlots)) u_len (
    .clk, .we, .addr(ptr[SlotW-1:0]), .wdata(wl), .rdata(hl));

  assign sts.ptr_last = (ptr[SlotW-1:0] == SlotW'(HoleSlots - 1));
  assign sts.is_free = (cmd_in == CmdFree);
  assign sts.fit = (hl != '0) && (hl >= size);
  assign sts.bump_ok = (bsum <= {1'b0, arena_limit});
  assign sts.outside = (lo < arena_base) ||
                       (({1'b0, lo} + {1'b0, size}) > {1'b0, arena_limit});
  assign sts.overlap = (hl != '0) && !(he < {1'b0, lo}) && !(hs > hi);
  assign sts.empty = (hl == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      arena_base <= ArenaBaseReset;
      arena_limit <= ArenaLimitReset;
      bump_pointer <= ArenaBaseReset;
    end else begin
      if (ctl.clr_ptr) ptr <= '0;
      else if (ctl.inc_ptr) ptr <= ptr + 1'b1;
      if (cfg_we && !busy) begin
        if (cfg_idx == RegArenaBase) begin
          arena_base <= cfg_data;
          bump_pointer <= cfg_data;
        end else begin
          arena_limit <= cfg_data;
        end
      end
      if (ctl.bump) bump_pointer <= bsum[AddrW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo <= base_in;
      hi <= base_in + size_in;
      size <= size_in;
      is_free <= (cmd_in == CmdFree);
      granted <= '0;
      stat <= StOk;
    end
    if (ctl.trim) granted <= hs;
    if (ctl.bump) granted <= bump_pointer;
    if (ctl.set_exh) stat <= StExhausted;
    if (ctl.set_out) stat <= StOutside;
    if (ctl.set_leak && is_free) stat <= StLeaked;
    if (ctl.merge) begin
      if (hs < lo) lo <= hs;
      if (he[AddrW-1:0] > hi) hi <= he[AddrW-1:0];
    end
  end
endmodule

// ===== rtl/first_fit_hole_allocator.sv =====
// First-fit hole allocator top level: controller plus datapath.
// One command at a time, set by the sequential scan over the single-port hole
// table.
// Reset: a clearing pass over every hole slot empties the table; no command
// is taken during it. Depends on ffha_pkg, ffha_ctrl, ffha_dp.
`timescale 1ns / 1ps
module first_fit_hole_allocator import ffha_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  logic [AddrW-1:0] range_base,
  input  logic [AddrW-1:0] size_bytes,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AddrW-1:0] granted_base,
  output logic [1:0]       status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [AddrW-1:0] cfg_data
);
  ctl_t ctl;
  sts_t sts;
  logic busy;

  assign cfg_ready = !busy;

  ffha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .ctl, .busy);

  ffha_dp u_dp (
    .clk, .rst, .ctl, .sts, .busy,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .cmd_in(command), .base_in(range_base), .size_in(size_bytes),
    .granted(granted_base), .stat(status));
endmodule
